FILE: rtl/core/msst_pkg.sv
// msst_pkg: constants, opcodes and status codes for the slot table.
// No dependencies.
`timescale 1ns / 1ps
package msst_pkg;
  localparam int unsigned NumStores  = 8;
  localparam int unsigned Slots      = 32;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned IdW        = 3;
  localparam int unsigned SlotW      = 5;
  localparam int unsigned SizeW      = 6;
  localparam int unsigned NidW       = 4;

  localparam logic [2:0] KindCreate = 3'd0;
  localparam logic [2:0] KindAdd    = 3'd1;
  localparam logic [2:0] KindDelVal = 3'd2;
  localparam logic [2:0] KindClear  = 3'd3;
  localparam logic [2:0] KindSearch = 3'd4;
  localparam logic [2:0] KindDelSt  = 3'd5;
  localparam logic [2:0] KindResize = 3'd6;
  localparam logic [2:0] KindUnused = 3'd7;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StRange   = 3'd1;
  localparam logic [2:0] StFull    = 3'd2;
  localparam logic [2:0] StNoStore = 3'd3;
  localparam logic [2:0] StNoId    = 3'd4;

  typedef struct packed {
    logic             live;
    logic [SizeW-1:0] size;
  } store_info_t;
endpackage

FILE: rtl/core/msst_cell.sv
// msst_cell: one slot of one store; words rotate through the chain of cells.
// Depends on msst_pkg.
`timescale 1ns / 1ps
module msst_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             shift_i,
  input  logic                             clr_i,
  input  logic [msst_pkg::ValueWidth-1:0]  word_i,
  output logic [msst_pkg::ValueWidth-1:0]  word_o
);
  import msst_pkg::*;
  logic [ValueWidth-1:0] word_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (clr_i) begin
      word_q <= '0;
    end else if (shift_i) begin
      word_q <= word_i;
    end
  end
  assign word_o = word_q;
endmodule

FILE: rtl/core/multi_store_slot_table.sv
// multi_store_slot_table: stores of slot words held in a rotating cell chain.
// Depends on msst_pkg and msst_cell.
//
// channel  dir  handshake          payload
// in       in   in_valid/in_stall  kind, store_id, value, use_index, slot_index, new_size
// out      out  out_valid/out_stall status, created_id, holder_mask
//
// Each transaction rotates the whole chain once past the one compare point at its
// head, shifting every slot word by one position, and then offers the result on
// the out channel; the next input transaction is taken once that result is accepted.
// Reset clears all cells and store records at once.
// A result held under out_stall blocks the next transaction.
`timescale 1ns / 1ps
module multi_store_slot_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         kind_i,
  input  logic [msst_pkg::IdW-1:0]           store_id_i,
  input  logic signed [31:0]                 value_i,
  input  logic                               use_index_i,
  input  logic [msst_pkg::SlotW-1:0]         slot_index_i,
  input  logic [msst_pkg::SizeW-1:0]         new_size_i,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         status_o,
  output logic [msst_pkg::IdW-1:0]           created_id_o,
  output logic [7:0]                         holder_mask_o
);
  import msst_pkg::*;
  localparam int unsigned Total = NumStores * Slots;
  localparam int unsigned PosW  = $clog2(Total + 1);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SRun  = 2'd1;
  localparam logic [1:0] SOut  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [PosW-1:0] pos_q;
  logic [2:0] kind_q;
  logic [IdW-1:0] id_q;
  logic [ValueWidth-1:0] val_q;
  logic use_q;
  logic [SlotW-1:0] idx_q;
  logic [SizeW-1:0] nsz_q;
  logic [2:0] status_q;
  logic [IdW-1:0] created_q;
  logic [7:0] mask;
  logic done_q;
  logic [NumStores-1:0] found_q;
  store_info_t info_q [NumStores];
  logic [NidW-1:0] nid_q;

  logic [ValueWidth-1:0] chain [Total+1];
  logic shift;
  logic [ValueWidth-1:0] head, head_new;

  for (genvar g = 0; g < Total; g++) begin : g_cell
    msst_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .clr_i  (1'b0),
      .word_i (chain[g+1]),
      .word_o (chain[g])
    );
  end
  assign head = chain[0];
  assign chain[Total] = head_new;
  assign shift = (state_q == SRun) && (pos_q != PosW'(Total));

  // position decode of the word at the head
  logic [IdW-1:0] cur_s;
  logic [SlotW-1:0] cur_k;
  logic [PosW-1:0] posx;
  assign posx  = pos_q;
  assign cur_s = IdW'(posx / PosW'(Slots));
  assign cur_k = SlotW'(posx % PosW'(Slots));

  logic [SizeW-1:0] cur_size;
  logic cur_live, in_store, own, hit;
  assign cur_size = info_q[cur_s].size;
  assign cur_live = info_q[cur_s].live;
  assign in_store = {1'b0, cur_k} < cur_size;
  assign own = cur_s == id_q;
  assign hit = head == val_q;

  // decision made at accept time; ok_q means the op mutates
  logic ok_q;
  always_comb begin
    head_new = head;
    if (ok_q) begin
      case (kind_q)
        KindCreate: if (own) head_new = '0;
        KindDelSt:  if (own) head_new = '0;
        KindResize: if (own && {1'b0, cur_k} >= nsz_q) head_new = '0;
        KindAdd: begin
          if (own && use_q && cur_k == idx_q) head_new = val_q;
          else if (own && !use_q && !done_q && in_store && head == '0)
            head_new = val_q;
        end
        KindDelVal: if (own && !done_q && in_store && hit) head_new = '0;
        KindClear:  if (own && cur_k == idx_q) head_new = '0;
        default: head_new = head;
      endcase
    end
  end

  logic known;
  assign known = info_q[store_id_i].live;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: if (in_valid) state_d = SRun;
      SRun:  if (pos_q == PosW'(Total)) state_d = SOut;
      SOut:  if (!out_stall) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      nid_q     <= '0;
      pos_q     <= '0;
      kind_q    <= '0;
      id_q      <= '0;
      val_q     <= '0;
      use_q     <= 1'b0;
      idx_q     <= '0;
      nsz_q     <= '0;
      status_q  <= StOk;
      created_q <= '0;
      done_q    <= 1'b0;
      found_q   <= '0;
      ok_q      <= 1'b0;
      for (int i = 0; i < NumStores; i++) info_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == SIdle && in_valid) begin
        pos_q <= '0;
        kind_q <= kind_i; id_q <= store_id_i; use_q <= use_index_i;
        idx_q <= slot_index_i; nsz_q <= new_size_i;
        val_q <= ValueWidth'(value_i);
        done_q <= 1'b0; found_q <= '0;
        status_q <= StOk; created_q <= '0; ok_q <= 1'b0;
        case (kind_i)
          KindCreate: begin
            if (new_size_i > SizeW'(Slots) || nid_q >= NidW'(NumStores)) begin
              status_q <= StNoId;
            end else begin
              ok_q <= 1'b1;
              id_q <= IdW'(nid_q);
              created_q <= IdW'(nid_q);
              info_q[IdW'(nid_q)] <= '{live: 1'b1, size: new_size_i};
              nid_q <= nid_q + 1'b1;
            end
          end
          KindAdd: begin
            if (!known) status_q <= StNoStore;
            else if (use_index_i && {1'b0, slot_index_i} >= info_q[store_id_i].size)
              status_q <= StRange;
            else begin
              ok_q <= 1'b1;
              if (!use_index_i) status_q <= StFull;
            end
          end
          KindDelVal: begin
            if (!known) status_q <= StNoStore;
            else ok_q <= 1'b1;
          end
          KindClear: begin
            if (!known) status_q <= StNoStore;
            else if ({1'b0, slot_index_i} >= info_q[store_id_i].size) status_q <= StRange;
            else ok_q <= 1'b1;
          end
          KindDelSt: begin
            if (!known) status_q <= StNoStore;
            else begin
              ok_q <= 1'b1;
              info_q[store_id_i] <= '0;
            end
          end
          KindResize: begin
            if (new_size_i > SizeW'(Slots)) status_q <= StNoId;
            else if (!known) status_q <= StNoStore;
            else begin
              ok_q <= 1'b1;
              info_q[store_id_i].size <= new_size_i;
            end
          end
          default: ok_q <= 1'b0;
        endcase
      end else if (shift) begin
        pos_q <= pos_q + 1'b1;
        if (ok_q && own && !done_q && in_store) begin
          if (kind_q == KindAdd && !use_q && head == '0) begin
            done_q <= 1'b1; status_q <= StOk;
          end
          if (kind_q == KindDelVal && hit) done_q <= 1'b1;
        end
        if (kind_q == KindSearch && cur_live && in_store && hit)
          found_q[cur_s] <= 1'b1;
      end
    end
  end

  always_comb begin
    mask = '0;
    for (int i = 0; i < NumStores && i < 8; i++) mask[i] = found_q[i];
  end

  assign in_stall      = state_q != SIdle;
  assign out_valid     = state_q == SOut;
  assign status_o      = status_q;
  assign created_id_o  = created_q;
  assign holder_mask_o = mask;
endmodule
